/* hw/rtl/mcg_pkg.sv */
// ----------------------------------------------------------------------------
// mcg_pkg
// Shared widths, marker codes and control structs for the combination
// generator.
// ----------------------------------------------------------------------------
package mcg_pkg;

    localparam int CFG_W  = 7;
    localparam int MASK_W = 64;
    localparam int POS_W  = 6;
    localparam int MARK_W = 8;

    typedef logic signed [MARK_W-1:0] mark_t;

    localparam mark_t MARK_LEFT = -8'sd2;
    localparam mark_t MARK_NEG  = -8'sd1;
    localparam mark_t MARK_ZERO = 8'sd0;
    localparam mark_t MARK_ONE  = 8'sd1;

    typedef enum logic {
        CFG_SET_SIZE,
        CFG_SUBSET_SIZE
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_INIT,
        OP_ADV,
        OP_BAD,
        OP_SKIP
    } step_op_t;

    typedef struct packed {
        logic             start;
        step_op_t         op;
        logic [CFG_W-1:0] n;
        logic [CFG_W-1:0] m;
        logic             ack;
    } seq_cmd_t;

    typedef struct packed {
        logic             done;
        logic             ok;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } seq_rsp_t;

endpackage

/* hw/rtl/minimal_change_combination_generator_top.sv */
// ----------------------------------------------------------------------------
// minimal_change_combination_generator_top
// Minimal-change m-of-n subset generator; marker array in a registered-read RAM.
// Throughput: one word in flight; s_ready returns in the same cycle as the result
// enters the output register. Reset: no subset until the first restart, n=8, m=3.
// ----------------------------------------------------------------------------
module minimal_change_combination_generator_top
    import mcg_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_restart,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [MASK_W-1:0] m_member_mask,
    output logic [POS_W-1:0]  m_moved_in,
    output logic [POS_W-1:0]  m_moved_out,
    output logic              m_produced,
    output logic              m_is_first,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int DEPTH = MAX_ELEMENTS + 2;
    localparam int AW    = $clog2(DEPTH);

    logic [CFG_W-1:0]  set_size_reg;
    logic [CFG_W-1:0]  subset_size_reg;
    logic [CFG_W-1:0]  lat_n_reg;
    logic [CFG_W-1:0]  lat_m_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              done_reg;
    logic              busy_reg;
    step_op_t          op_reg;
    logic              m_valid_reg;
    logic [MASK_W-1:0] m_mask_reg;
    logic [POS_W-1:0]  m_in_reg;
    logic [POS_W-1:0]  m_out_reg;
    logic              m_produced_reg;
    logic              m_first_reg;

    logic [MASK_W-1:0] m_mask_next;
    logic [POS_W-1:0]  m_in_next;
    logic [POS_W-1:0]  m_out_next;
    logic              m_produced_next;
    logic              m_first_next;

    logic              s_acc;
    logic              cfg_ok;
    step_op_t          op_sel;
    step_op_t          op_cur;
    logic              out_free;
    logic              take;
    logic [MASK_W-1:0] init_mask;
    logic [MASK_W-1:0] adv_mask;

    seq_cmd_t          cmd;
    seq_rsp_t          rsp;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    mark_t             ram_wr_data;
    logic [AW-1:0]     ram_rd_addr;
    mark_t             ram_rd_data;

    assign s_ready  = !busy_reg;
    assign s_acc    = s_valid && s_ready;
    assign cfg_ok   = (set_size_reg != '0) && (subset_size_reg != '0) &&
                      (subset_size_reg <= set_size_reg) &&
                      (set_size_reg <= CFG_W'(MAX_ELEMENTS));
    assign op_sel   = s_restart ? (cfg_ok ? OP_INIT : OP_BAD)
                                : (done_reg ? OP_SKIP : OP_ADV);
    assign op_cur   = s_acc ? op_sel : op_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign take     = rsp.done && out_free;

    assign init_mask = {MASK_W{1'b1}} >> (CFG_W'(MASK_W) - subset_size_reg);
    assign adv_mask  = (mask_reg | (MASK_W'(1) << rsp.x)) & ~(MASK_W'(1) << rsp.y);

    assign cmd.start = s_acc;
    assign cmd.op    = op_cur;
    assign cmd.n     = (op_cur == OP_INIT) ? set_size_reg : lat_n_reg;
    assign cmd.m     = subset_size_reg;
    assign cmd.ack   = take;

    mcg_marker_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mcg_twiddle_seq #(
        .AW (AW)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rsp     (rsp),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        m_mask_next     = '0;
        m_in_next       = '0;
        m_out_next      = '0;
        m_produced_next = 1'b0;
        m_first_next    = 1'b0;
        unique case (op_reg)
            OP_INIT: begin
                m_mask_next     = init_mask;
                m_produced_next = 1'b1;
                m_first_next    = 1'b1;
            end
            OP_ADV: begin
                if (rsp.ok) begin
                    m_mask_next     = adv_mask;
                    m_in_next       = rsp.x;
                    m_out_next      = rsp.y;
                    m_produced_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_size_reg    <= CFG_W'(8);
            subset_size_reg <= CFG_W'(3);
            lat_n_reg       <= '0;
            lat_m_reg       <= '0;
            mask_reg        <= '0;
            done_reg        <= 1'b1;
            busy_reg        <= 1'b0;
            op_reg          <= OP_SKIP;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_SET_SIZE:    set_size_reg    <= cfg_wdata;
                    CFG_SUBSET_SIZE: subset_size_reg <= cfg_wdata;
                    default:         ;
                endcase
            end

            if (s_acc) begin
                busy_reg <= 1'b1;
                op_reg   <= op_sel;
            end

            if (take) begin
                busy_reg       <= 1'b0;
                m_valid_reg    <= 1'b1;
                m_mask_reg     <= m_mask_next;
                m_in_reg       <= m_in_next;
                m_out_reg      <= m_out_next;
                m_produced_reg <= m_produced_next;
                m_first_reg    <= m_first_next;
                unique case (op_reg)
                    OP_INIT: begin
                        lat_n_reg <= set_size_reg;
                        lat_m_reg <= subset_size_reg;
                        mask_reg  <= init_mask;
                        done_reg  <= 1'b0;
                    end
                    OP_ADV: begin
                        if (rsp.ok) begin
                            mask_reg <= adv_mask;
                        end else begin
                            done_reg <= 1'b1;
                        end
                    end
                    OP_BAD: begin
                        mask_reg <= '0;
                        done_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_member_mask = m_mask_reg;
    assign m_moved_in    = m_in_reg;
    assign m_moved_out   = m_out_reg;
    assign m_produced    = m_produced_reg;
    assign m_is_first    = m_first_reg;

`ifndef SYNTHESIS
    a_mask_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        !done_reg |-> ($countones(mask_reg) == int'(lat_m_reg)))
        else $error("live mask weight differs from subset size");

    a_move_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_produced && !m_is_first) |->
            (m_member_mask[m_moved_in] && !m_member_mask[m_moved_out]))
        else $error("moved positions disagree with mask");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> busy_reg)
        else $error("sequencer result without a word in flight");
`endif

endmodule

/* hw/rtl/mcg_marker_ram.sv */
// ----------------------------------------------------------------------------
// mcg_marker_ram
// Marker array store: one write port, one read port, registered read with
// write-to-read forwarding on an address match.
// ----------------------------------------------------------------------------
module mcg_marker_ram
    import mcg_pkg::*;
#(
    parameter int DEPTH = 66,
    parameter int AW    = 7
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  mark_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output mark_t         rd_data
);

    mark_t mem [DEPTH];
    mark_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/mcg_twiddle_seq.sv */
// ----------------------------------------------------------------------------
// mcg_twiddle_seq
// Step sequencer: loads the marker array on a valid restart and walks it one entry
// per cycle for each advance, writing back the updated markers.
// ----------------------------------------------------------------------------
module mcg_twiddle_seq
    import mcg_pkg::*;
#(
    parameter int AW = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  seq_cmd_t      cmd,
    output seq_rsp_t      rsp,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output mark_t         wr_data,
    output logic [AW-1:0] rd_addr,
    input  mark_t         rd_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN1,
        S_CHK,
        S_FILLA,
        S_SCAN2,
        S_ZERO,
        S_WR2,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    j_reg, j_next;
    logic [AW-1:0]    k_reg, k_next;
    mark_t            pk_reg, pk_next;
    logic [AW-1:0]    w2_addr_reg, w2_addr_next;
    mark_t            w2_data_reg, w2_data_next;
    logic             ok_reg, ok_next;
    logic [POS_W-1:0] x_reg, x_next;
    logic [POS_W-1:0] y_reg, y_next;

    logic [AW-1:0]    n_a;
    logic [AW-1:0]    m_a;
    logic [AW-1:0]    np1;
    mark_t            init_val;

    function automatic logic [POS_W-1:0] pos_of(input logic [AW-1:0] a);
        return POS_W'(a - AW'(1));
    endfunction

    assign n_a = AW'(cmd.n);
    assign m_a = AW'(cmd.m);
    assign np1 = AW'(n_a + AW'(1));

    always_comb begin
        if (idx_reg == '0) begin
            init_val = MARK_LEFT;
        end else if (idx_reg <= m_a) begin
            init_val = mark_t'(MARK_W'(m_a) - MARK_W'(idx_reg) + MARK_W'(1));
        end else if (idx_reg == np1) begin
            init_val = mark_t'(MARK_W'(np1));
        end else begin
            init_val = MARK_ZERO;
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        pk_next      = pk_reg;
        w2_addr_next = w2_addr_reg;
        w2_data_next = w2_data_reg;
        ok_next      = ok_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = MARK_ZERO;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd.start) begin
                    unique case (cmd.op)
                        OP_INIT: begin
                            idx_next   = '0;
                            state_next = S_INIT;
                        end
                        OP_ADV: begin
                            idx_next   = n_a;
                            state_next = S_SCAN1;
                        end
                        default: begin
                            ok_next    = 1'b0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INIT: begin
                wr_en   = 1'b1;
                wr_data = init_val;
                if (idx_reg == np1) begin
                    ok_next    = 1'b1;
                    x_next     = '0;
                    y_next     = '0;
                    state_next = S_DONE;
                end else begin
                    idx_next = AW'(idx_reg + AW'(1));
                end
            end
            S_SCAN1: begin
                if (idx_reg == '0) begin
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end else if (rd_data > MARK_ZERO) begin
                    j_next     = idx_reg;
                    pk_next    = rd_data;
                    idx_next   = AW'(idx_reg + AW'(1));
                    state_next = S_CHK;
                end else begin
                    idx_next = AW'(idx_reg - AW'(1));
                end
            end
            S_CHK: begin
                if (rd_data == MARK_ZERO) begin
                    wr_en      = 1'b1;
                    wr_addr    = j_reg;
                    wr_data    = MARK_ZERO;
                    state_next = S_FILLA;
                end else begin
                    wr_en      = (j_reg != n_a);
                    wr_addr    = idx_reg;
                    wr_data    = MARK_ZERO;
                    idx_next   = AW'(j_reg - AW'(1));
                    state_next = S_SCAN2;
                end
            end
            S_FILLA: begin
                wr_en = 1'b1;
                if (idx_reg == n_a) begin
                    wr_data    = MARK_ONE;
                    ok_next    = 1'b1;
                    x_next     = pos_of(n_a);
                    y_next     = pos_of(j_reg);
                    state_next = S_DONE;
                end else begin
                    wr_data  = MARK_NEG;
                    idx_next = AW'(idx_reg + AW'(1));
                end
            end
            S_SCAN2: begin
                if ((idx_reg != '0) && (rd_data > MARK_ZERO)) begin
                    pk_next  = rd_data;
                    idx_next = AW'(idx_reg - AW'(1));
                end else begin
                    j_next     = idx_reg;
                    k_next     = AW'(idx_reg + AW'(1));
                    state_next = S_ZERO;
                end
            end
            S_ZERO: begin
                if ((idx_reg != '0) && (rd_data == MARK_ZERO)) begin
                    wr_en    = 1'b1;
                    wr_data  = MARK_NEG;
                    idx_next = AW'(idx_reg - AW'(1));
                end else if (rd_data == MARK_NEG) begin
                    wr_en        = 1'b1;
                    wr_data      = pk_reg;
                    w2_addr_next = k_reg;
                    w2_data_next = MARK_NEG;
                    ok_next      = 1'b1;
                    x_next       = pos_of(idx_reg);
                    y_next       = pos_of(k_reg);
                    state_next   = S_WR2;
                end else if (idx_reg == '0) begin
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end else begin
                    wr_en        = 1'b1;
                    wr_addr      = j_reg;
                    wr_data      = rd_data;
                    w2_addr_next = idx_reg;
                    w2_data_next = MARK_ZERO;
                    ok_next      = 1'b1;
                    x_next       = pos_of(j_reg);
                    y_next       = pos_of(idx_reg);
                    state_next   = S_WR2;
                end
            end
            S_WR2: begin
                wr_en      = 1'b1;
                wr_addr    = w2_addr_reg;
                wr_data    = w2_data_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (cmd.ack) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            ok_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            ok_reg      <= ok_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            pk_reg      <= pk_next;
            w2_addr_reg <= w2_addr_next;
            w2_data_reg <= w2_data_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
        end
    end

    assign rd_addr  = idx_next;
    assign rsp.done = (state_reg == S_DONE);
    assign rsp.ok   = ok_reg;
    assign rsp.x    = x_reg;
    assign rsp.y    = y_reg;

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the minimal-change combination generator. A
// driver sends restart/advance words in random bursts, a monitor takes
// results under a changing stall pattern, and an in-bench twiddle predictor
// checks every field of each result word. Registers change only while idle.
// ----------------------------------------------------------------------------
module tb_top;
    import mcg_pkg::*;

    localparam int MAX_ELEMENTS  = 64;
    localparam int WORDS_TARGET  = 1100;
    localparam int RUN_LIMIT     = 10_000_000;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_PERIODIC
    } stall_t;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [POS_W-1:0]  pos_in;
        logic [POS_W-1:0]  pos_out;
        logic              produced;
        logic              first;
    } subset_word_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_restart = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [MASK_W-1:0] m_member_mask;
    logic [POS_W-1:0]  m_moved_in;
    logic [POS_W-1:0]  m_moved_out;
    logic              m_produced;
    logic              m_is_first;
    logic              cfg_wr_en = 1'b0;
    cfg_reg_t          cfg_index = CFG_SET_SIZE;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    minimal_change_combination_generator_top #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_member_mask (m_member_mask),
        .m_moved_in    (m_moved_in),
        .m_moved_out   (m_moved_out),
        .m_produced    (m_produced),
        .m_is_first    (m_is_first),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("tb_top: errors");
        $finish;
    end

    // predictor state
    logic [CFG_W-1:0]  set_size_reg = 7'd8;
    logic [CFG_W-1:0]  subset_size_reg = 7'd3;
    mark_t             marks [0:MAX_ELEMENTS+1];
    logic [MASK_W-1:0] cur_mask = '0;
    logic              gen_done = 1'b1;
    int                live_n = 0;

    bit                pending_words [$];
    subset_word_t      subsets_due [$];
    int                words_sent = 0;
    int                err_count = 0;

    // one twiddle step on the marker array; 0 when the scheme runs out
    function automatic bit twiddle(output int xin, output int yout);
        int n, i, j, k;
        n = live_n;
        xin = 0;
        yout = 0;
        j = n;
        while (j > 0 && marks[j] <= 0) j--;
        if (j <= 0) return 1'b0;
        if (marks[j+1] == MARK_ZERO) begin
            for (i = j + 1; i < n; i++) marks[i] = MARK_NEG;
            marks[j] = MARK_ZERO;
            marks[n] = MARK_ONE;
            xin = n - 1;
            yout = j - 1;
            return 1'b1;
        end
        if (j < n) marks[j+1] = MARK_ZERO;
        j--;
        while (j > 0 && marks[j] > 0) j--;
        k = j + 1;
        i = j;
        while (i > 0 && marks[i] == MARK_ZERO) begin
            marks[i] = MARK_NEG;
            i--;
        end
        if (marks[i] == MARK_NEG) begin
            marks[i] = marks[k];
            marks[k] = MARK_NEG;
            xin = i - 1;
            yout = k - 1;
            return 1'b1;
        end
        if (i <= 0) return 1'b0;
        marks[j] = marks[i];
        marks[i] = MARK_ZERO;
        xin = j - 1;
        yout = i - 1;
        return 1'b1;
    endfunction

    function automatic subset_word_t next_subset(input logic restart);
        subset_word_t w;
        int n, m, xin, yout;
        w = '0;
        if (restart) begin
            n = int'(set_size_reg);
            m = int'(subset_size_reg);
            if (n == 0 || m == 0 || m > n || n > MAX_ELEMENTS) begin
                gen_done = 1'b1;
                cur_mask = '0;
            end else begin
                live_n = n;
                foreach (marks[i]) marks[i] = MARK_ZERO;
                marks[0] = MARK_LEFT;
                for (int i = 1; i <= m; i++) marks[i] = mark_t'(m - i + 1);
                marks[n+1] = mark_t'(n + 1);
                cur_mask = (m >= 64) ? '1 : ((64'd1 << m) - 64'd1);
                gen_done = 1'b0;
                w.mask = cur_mask;
                w.produced = 1'b1;
                w.first = 1'b1;
            end
        end else if (!gen_done) begin
            if (!twiddle(xin, yout)) begin
                gen_done = 1'b1;
            end else begin
                cur_mask |= 64'd1 << xin[5:0];
                cur_mask &= ~(64'd1 << yout[5:0]);
                w.mask = cur_mask;
                w.pos_in = xin[5:0];
                w.pos_out = yout[5:0];
                w.produced = 1'b1;
            end
        end
        return w;
    endfunction

    // number of subsets, capped
    function automatic int ways(input int n, input int m);
        longint c;
        int k;
        if (n == 0 || m == 0 || m > n || n > MAX_ELEMENTS) return 0;
        k = (m < n - m) ? m : n - m;
        c = 1;
        for (int i = 1; i <= k; i++) begin
            c = c * (n - k + i) / i;
            if (c > 1000) return 1000;
        end
        return int'(c);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= 100)
            $display("tb_top: %s mismatch, got %0h want %0h", what, got, want);
    endtask

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_restart <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready)
                subsets_due = {subsets_due, next_subset(s_restart)};
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || pending_words.size() == 0) begin
                    if (gap_left > 0) gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_restart <= pending_words.pop_front();
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
    end

    // monitor: result checks and receiver stall pattern
    stall_t stall_mode = READY_ALWAYS;
    int     mode_left = 0;
    int     tick = 0;

    always @(posedge aclk) begin
        subset_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_mode <= READY_ALWAYS;
            mode_left <= 0;
        end else begin
            tick <= tick + 1;
            if (m_valid && m_ready) begin
                if (subsets_due.size() == 0) begin
                    report_mismatch("unexpected word", m_member_mask, '0);
                end else begin
                    want = subsets_due.pop_front();
                    if (m_member_mask !== want.mask)
                        report_mismatch("member_mask", m_member_mask, want.mask);
                    if (m_moved_in !== want.pos_in)
                        report_mismatch("moved_in", 64'(m_moved_in), 64'(want.pos_in));
                    if (m_moved_out !== want.pos_out)
                        report_mismatch("moved_out", 64'(m_moved_out), 64'(want.pos_out));
                    if (m_produced !== want.produced)
                        report_mismatch("produced", 64'(m_produced), 64'(want.produced));
                    if (m_is_first !== want.first)
                        report_mismatch("is_first", 64'(m_is_first), 64'(want.first));
                end
            end
            if (mode_left == 0) begin
                stall_mode <= stall_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(50, 300);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                READY_ALWAYS:   m_ready <= 1'b1;
                READY_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
                READY_RARELY:   m_ready <= ($urandom_range(0, 3) == 0);
                default:        m_ready <= tick[2];
            endcase
        end
    end

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || subsets_due.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        if (idx == CFG_SET_SIZE) set_size_reg = val[CFG_W-1:0];
        else subset_size_reg = val[CFG_W-1:0];
    endtask

    task automatic start_phase(input bit wr_n, input int n_val, input bit wr_m,
                               input int m_val);
        wait_idle();
        if (wr_n) write_reg(CFG_SET_SIZE, n_val);
        if (wr_m) write_reg(CFG_SUBSET_SIZE, m_val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_word(input bit restart);
        pending_words = {pending_words, restart};
        words_sent++;
    endtask

    task automatic queue_walk(input bit with_restart, input int advances);
        if (with_restart) queue_word(1'b1);
        repeat (advances) queue_word(1'b0);
    endtask

    initial begin
        int kind, n_pick, m_pick, steps;
        foreach (marks[i]) marks[i] = MARK_ZERO;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: never restarted, reset registers, then edge configurations
        queue_walk(1'b0, 1);
        queue_walk(1'b1, 3);
        start_phase(1, 1, 1, 1);
        queue_walk(1'b1, 2);
        start_phase(1, 64, 1, 64);
        queue_walk(1'b1, 1);
        start_phase(0, 0, 1, 1);
        queue_walk(1'b1, 3);
        start_phase(1, 5, 1, 6);
        queue_walk(1'b1, 1);
        start_phase(1, 0, 1, 0);
        queue_walk(1'b1, 0);
        start_phase(1, 127, 1, 127);
        queue_walk(1'b1, 0);
        start_phase(1, 65, 1, 1);
        queue_walk(1'b1, 1);
        // register writes mid-walk stay pending until the next restart
        start_phase(1, 4, 1, 2);
        queue_walk(1'b1, 2);
        start_phase(1, 3, 1, 1);
        queue_walk(1'b0, 2);

        while (words_sent < WORDS_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                n_pick = $urandom_range(40, 64);
                case ($urandom_range(0, 3))
                    0:       m_pick = 1;
                    1:       m_pick = 2;
                    2:       m_pick = n_pick - 1;
                    default: m_pick = n_pick;
                endcase
                start_phase(1, n_pick, 1, m_pick);
                steps = ways(n_pick, m_pick) + $urandom_range(0, 2);
                queue_walk(1'b1, (steps > 70) ? 70 : steps);
            end else if (kind < 75) begin
                n_pick = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 10 : 7);
                m_pick = $urandom_range(1, n_pick);
                start_phase($urandom_range(0, 3) != 0, n_pick,
                            $urandom_range(0, 3) != 0, m_pick);
                if ($urandom_range(0, 5) == 0)
                    queue_walk(1'b0, $urandom_range(1, 8));
                steps = ways(int'(set_size_reg), int'(subset_size_reg)) +
                        $urandom_range(0, 2);
                queue_walk(1'b1, (steps > 120) ? 120 : steps);
            end else if (kind < 85) begin
                case ($urandom_range(0, 3))
                    0:       n_pick = 0;
                    1:       n_pick = $urandom_range(65, 127);
                    2:       n_pick = 127;
                    default: n_pick = $urandom_range(1, 20);
                endcase
                case ($urandom_range(0, 2))
                    0:       m_pick = 0;
                    1:       m_pick = 127;
                    default: m_pick = (n_pick + $urandom_range(1, 10)) % 128;
                endcase
                start_phase(1, n_pick, 1, m_pick);
                queue_walk(1'b1, $urandom_range(0, 3));
            end else begin
                n_pick = $urandom_range(1, 12);
                m_pick = $urandom_range(0, n_pick + 1);
                start_phase(1, n_pick, 1, m_pick);
                repeat ($urandom_range(20, 40))
                    queue_word($urandom_range(0, 3) == 0);
            end
        end

        wait_idle();
        repeat (200) @(posedge aclk);
        if (err_count == 0 && subsets_due.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
